>>> design/crca_pkg.sv
// Package for the calorimeter ring cluster accumulator.
// Holds shared constants and the front-to-back command type; no dependencies.
`default_nettype none
package crca_pkg;
    localparam int MAX_RING_DEF    = 7;
    localparam int SIGNAL_BITS_DEF = 16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNUSABLE = 2'd1;
    localparam logic [1:0] ST_NOSTART  = 2'd2;
    localparam logic [1:0] ST_RING     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_DIVR, S_DIVC, S_EMIT
    } t_back_state;

    // Command from front to back: the item as classified by the front part.
    typedef struct packed {
        logic        start;
        logic        apply;
        logic [1:0]  status;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  drow;
        logic [7:0]  dcol;
        logic [4:0]  ring;
        logic [23:0] sig;
    } t_cmd;
endpackage
`default_nettype wire

>>> design/crca_front.sv
// Front part: accepts items and classifies them against the cluster centre.
// Depends on crca_pkg; keeps a shadow of the centre and the started flag.
`default_nettype none
module crca_front import crca_pkg::*; #(
    parameter int MAX_RING    = MAX_RING_DEF,
    parameter int SIGNAL_BITS = SIGNAL_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_module_row,
    input  wire logic [7:0]  i_module_col,
    input  wire logic [15:0] i_module_signal,
    input  wire logic        i_module_usable,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_stall,
    output t_cmd             o_cmd
);
    logic       r_started;
    logic [7:0] r_crow, r_ccol;
    logic [7:0] drow, dcol, dmax;
    t_cmd       cmd;
    logic       acc;

    assign o_cmd_valid = i_valid;
    assign o_stall     = i_cmd_stall;
    assign acc         = i_valid && !i_cmd_stall;

    always_comb begin
        drow = (r_crow > i_module_row) ? r_crow - i_module_row : i_module_row - r_crow;
        dcol = (r_ccol > i_module_col) ? r_ccol - i_module_col : i_module_col - r_ccol;
        dmax = (dcol > drow) ? dcol : drow;
        cmd        = '0;
        cmd.row    = i_module_row;
        cmd.col    = i_module_col;
        cmd.drow   = drow;
        cmd.dcol   = dcol;
        cmd.ring   = dmax[4:0];
        cmd.sig    = 24'(i_module_signal[SIGNAL_BITS > 16 ? 15 : SIGNAL_BITS-1:0]);
        cmd.start  = !i_op;
        if (!i_op) begin
            cmd.status = i_module_usable ? ST_OK : ST_UNUSABLE;
            cmd.apply  = i_module_usable;
        end else if (!r_started) begin
            cmd.status = ST_NOSTART;
        end else if (!i_module_usable) begin
            cmd.status = ST_UNUSABLE;
        end else if (32'(dmax) > 32'(MAX_RING)) begin
            cmd.status = ST_RING;
        end else begin
            cmd.status = ST_OK;
            cmd.apply  = 1'b1;
        end
    end
    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_crow    <= '0;
            r_ccol    <= '0;
        end else if (acc && !i_op) begin
            r_started <= i_module_usable;
            r_crow    <= i_module_usable ? i_module_row : 8'd0;
            r_ccol    <= i_module_usable ? i_module_col : 8'd0;
        end
    end
endmodule
`default_nettype wire

>>> design/crca_queue.sv
// Two-entry queue of classified commands between front and back parts.
// Depends on crca_pkg for the command type.
`default_nettype none
module crca_queue import crca_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_cmd      o_cmd
);
    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

>>> design/crca_back.sv
// Back part: updates ring values and moments, divides, and emits results.
// Depends on crca_pkg; the ring values live in a small register array.
`default_nettype none
module crca_back import crca_pkg::*; #(
    parameter int MAX_RING = MAX_RING_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_stall,
    input  t_cmd             i_cmd,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_value_index,
    output logic [31:0]      o_value_sum,
    output logic             o_last_value,
    output logic [1:0]       o_status,
    output logic             o_module_taken,
    output logic [7:0]       o_module_count,
    output logic [7:0]       o_center_row,
    output logic [7:0]       o_center_col,
    output logic [15:0]      o_row_dispersion,
    output logic [15:0]      o_col_dispersion
);
    localparam int TOP = MAX_RING + 2;
    localparam int VB  = $clog2(TOP + 1);

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [31:0] r_val [1:TOP];
    logic [VB-1:0] r_vcnt, r_emit;
    logic [7:0]  r_mcnt, r_crow, r_ccol;
    logic [31:0] r_rmom, r_cmom;
    logic [15:0] r_rdisp, r_cdisp;
    logic [1:0]  r_status;
    logic        r_taken;
    // Serial divider: restoring, one quotient bit a cycle.
    logic [40:0] r_rem;
    logic [39:0] r_quo;
    logic [5:0]  r_dcnt;
    logic [31:0] r_mul_r, r_mul_c;
    logic [47:0] pr, pc;
    logic [VB-1:0] slot;
    logic [40:0] trial;
    logic [39:0] q_next;
    logic        div_done, emit_last, acc_out;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = 49'(a) + 49'(b);
        return (s > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign slot      = VB'(r_cmd.ring) + VB'(2);
    assign pr        = 48'(r_mul_r) * 48'(r_cmd.drow);
    assign pc        = 48'(r_mul_c) * 48'(r_cmd.dcol);
    assign trial     = {r_rem[39:0], r_quo[39]} - {9'd0, r_val[1]};
    assign q_next    = {r_quo[38:0], !trial[40]};
    assign div_done  = (r_dcnt == 6'd0);
    assign emit_last = (r_vcnt == 0) || (r_emit == r_vcnt);
    assign acc_out   = o_valid && !i_stall;

    assign o_cmd_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_cmd_valid) n_state = S_UPD;
            S_UPD:  n_state = S_DIVR;
            S_DIVR: if (div_done) n_state = S_DIVC;
            S_DIVC: if (div_done) n_state = S_EMIT;
            S_EMIT: if (acc_out && emit_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_valid          = (r_state == S_EMIT);
        o_value_index    = (r_vcnt == 0) ? 4'd0 : 4'(r_emit);
        o_value_sum      = (r_vcnt == 0) ? 32'd0 : r_val[r_emit];
        o_last_value     = emit_last;
        o_status         = r_status;
        o_module_taken   = r_taken;
        o_module_count   = r_mcnt;
        o_center_row     = r_crow;
        o_center_col     = r_ccol;
        o_row_dispersion = r_rdisp;
        o_col_dispersion = r_cdisp;
    end

    function automatic logic [15:0] sat16(input logic [39:0] q);
        return (q > 40'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_mcnt  <= '0;
            r_crow  <= '0;
            r_ccol  <= '0;
            r_rmom  <= '0;
            r_cmom  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd    <= i_cmd;
                    // First multiplication stage: signal times distance.
                    r_mul_r  <= 32'(i_cmd.sig) * 32'(i_cmd.drow);
                    r_mul_c  <= 32'(i_cmd.sig) * 32'(i_cmd.dcol);
                end
                S_UPD: begin
                    r_status <= r_cmd.status;
                    r_taken  <= r_cmd.apply;
                    if (r_cmd.start) begin
                        r_crow <= r_cmd.apply ? r_cmd.row : 8'd0;
                        r_ccol <= r_cmd.apply ? r_cmd.col : 8'd0;
                        r_mcnt <= r_cmd.apply ? 8'd1 : 8'd0;
                        r_vcnt <= r_cmd.apply ? VB'(1) : VB'(0);
                        r_rmom <= '0;
                        r_cmom <= '0;
                        r_val[1] <= 32'(r_cmd.sig);
                    end else if (r_cmd.apply) begin
                        for (int i = 2; i <= TOP; i++) begin
                            if (VB'(i) >= slot && VB'(i) <= r_vcnt)
                                r_val[i] <= sat_add(r_val[i], 48'(r_cmd.sig));
                            else if (VB'(i) > r_vcnt && VB'(i) < slot)
                                r_val[i] <= r_val[r_vcnt];
                            else if (VB'(i) == slot)
                                r_val[i] <= sat_add(r_val[r_vcnt], 48'(r_cmd.sig));
                        end
                        r_val[1] <= sat_add(r_val[1], 48'(r_cmd.sig));
                        if (slot > r_vcnt) r_vcnt <= slot;
                        if (r_mcnt != 8'hFF) r_mcnt <= r_mcnt + 8'd1;
                        r_rmom <= sat_add(r_rmom, pr);
                        r_cmom <= sat_add(r_cmom, pc);
                    end
                    r_dcnt <= 6'd40;
                    r_rem  <= '0;
                    r_quo  <= '0;
                end
                S_DIVR, S_DIVC: begin
                    if (r_dcnt == 6'd40) begin
                        r_quo  <= {(r_state == S_DIVR) ? r_rmom : r_cmom, 8'd0};
                        r_rem  <= '0;
                        r_dcnt <= 6'd39;
                    end else begin
                        r_rem  <= trial[40] ? {r_rem[39:0], r_quo[39]} : trial;
                        r_quo  <= q_next;
                        if (div_done) begin
                            if (r_state == S_DIVR)
                                r_rdisp <= (r_vcnt == 0 || r_val[1] == 0) ? 16'd0 : sat16(q_next);
                            else
                                r_cdisp <= (r_vcnt == 0 || r_val[1] == 0) ? 16'd0 : sat16(q_next);
                            r_dcnt <= 6'd40;
                            r_emit <= VB'(1);
                        end else begin
                            r_dcnt <= r_dcnt - 6'd1;
                        end
                    end
                end
                S_EMIT: if (acc_out) r_emit <= r_emit + VB'(1);
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/calorimeter_ring_cluster_accumulator_top.sv
// Builds one calorimeter cluster from module hits and reports all ring sums
// after each item. An item passes these steps in order: the back part takes
// the command, an update step, two serial divisions (each a load step and 40
// quotient bits) for the dispersions, then one result per stored value, or a
// single zero result if none is stored. A two-entry queue lets the front part
// keep taking items while the back part works.
// Depends on crca_pkg, crca_front, crca_queue and crca_back.
`default_nettype none
module calorimeter_ring_cluster_accumulator_top import crca_pkg::*; #(
    parameter int MAX_RING    = MAX_RING_DEF,
    parameter int SIGNAL_BITS = SIGNAL_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_module_row,
    input  wire logic [7:0]  i_module_col,
    input  wire logic [15:0] i_module_signal,
    input  wire logic        i_module_usable,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_value_index,
    output logic [31:0]      o_value_sum,
    output logic             o_last_value,
    output logic [1:0]       o_status,
    output logic             o_module_taken,
    output logic [7:0]       o_module_count,
    output logic [7:0]       o_center_row,
    output logic [7:0]       o_center_col,
    output logic [15:0]      o_row_dispersion,
    output logic [15:0]      o_col_dispersion
);
    t_cmd f_cmd, q_cmd;
    logic f_valid, f_stall, q_valid, q_stall;

    crca_front #(.MAX_RING(MAX_RING), .SIGNAL_BITS(SIGNAL_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_module_row, .i_module_col,
        .i_module_signal, .i_module_usable,
        .o_cmd_valid(f_valid), .i_cmd_stall(f_stall), .o_cmd(f_cmd));

    crca_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_cmd(f_cmd),
        .o_valid(q_valid), .i_stall(q_stall), .o_cmd(q_cmd));

    crca_back #(.MAX_RING(MAX_RING)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(q_valid), .o_cmd_stall(q_stall), .i_cmd(q_cmd),
        .o_valid, .i_stall, .o_value_index, .o_value_sum, .o_last_value, .o_status,
        .o_module_taken, .o_module_count, .o_center_row, .o_center_col,
        .o_row_dispersion, .o_col_dispersion);
endmodule
`default_nettype wire
